FILE: rtl/assert_macros.svh
// Assertion macros; clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FWWP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FWWP_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);
`else
`define FWWP_ASSERT(lbl, prop, msg)
`define FWWP_ASSERT_NEXT(lbl, cond, expr, msg)
`endif
`endif

FILE: rtl/fwwp_pkg.sv
package fwwp_pkg;

    // defaults for the top-level parameters
    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int ADDR_BITS_DEF    = 24;

    // fixed field widths
    localparam int LOC_BITS   = 24;
    localparam int WORD_BITS  = 32;
    localparam int WORD_BYTES = 4;

    localparam logic [7:0] PAD_BYTE = 8'hFF;

    // input opcodes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // result commands
    localparam logic [0:0] CMD_ERASE   = 1'b0;
    localparam logic [0:0] CMD_PROGRAM = 1'b1;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [0:0]           command;
        logic [LOC_BITS-1:0]  location;
        logic [WORD_BITS-1:0] word_data;
    } out_item_t;

endpackage

FILE: rtl/flash_word_write_packer.sv
// A result is registered and presented in the cycle after the item that causes it is accepted.
// Throughput: one item per cycle; the single output register stalls the input only
// while it holds a result that the sink has not taken.
// SECTOR_BYTES must be a power of two, which the block does not check; sector indexes
// come from a plain bit-select. Reset (rst_n low, asynchronous) clears pointer,
// pending count, erase mark, start address and the output valid.
`include "assert_macros.svh"

module flash_word_write_packer #(
    parameter int SECTOR_BYTES = fwwp_pkg::SECTOR_BYTES_DEF,
    parameter int ADDR_BITS    = fwwp_pkg::ADDR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fwwp_pkg::LOC_BITS-1:0] cfg_data,
    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  fwwp_pkg::in_item_t            in_item,
    // result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output fwwp_pkg::out_item_t           out_item
);
    import fwwp_pkg::*;

    localparam int SHIFT       = $clog2(SECTOR_BYTES);
    localparam int SECTOR_BITS = ADDR_BITS - SHIFT;
    localparam int EXT_BITS    = ADDR_BITS + LOC_BITS;

    logic [LOC_BITS-1:0]  start_address_reg;
    logic [ADDR_BITS-1:0] write_pointer_reg, write_pointer_next;
    logic [1:0]           pending_count_reg, pending_count_next;
    logic [7:0]           pending_bytes_reg [3];
    logic [SECTOR_BITS:0] next_erase_reg, next_erase_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg, out_item_next;

    logic                 in_accept;
    logic                 store_byte;
    logic [ADDR_BITS-1:0] byte_addr;
    logic [SECTOR_BITS:0] byte_sector;
    logic [ADDR_BITS-1:0] start_pointer;
    logic [EXT_BITS-1:0]  start_ext;
    logic [EXT_BITS-1:0]  wp_ext;
    logic [EXT_BITS-1:0]  sector_ext;
    logic [7:0]           pack_b0, pack_b1, pack_b2;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // byte address of the incoming data byte; pointer is word aligned
    assign byte_addr   = {write_pointer_reg[ADDR_BITS-1:2], pending_count_reg};
    assign byte_sector = {1'b0, byte_addr[ADDR_BITS-1:SHIFT]};

    // start pointer: config value fitted to ADDR_BITS, low two bits dropped
    assign start_ext     = {{ADDR_BITS{1'b0}}, start_address_reg};
    assign start_pointer = {start_ext[ADDR_BITS-1:2], 2'b00};

    assign wp_ext     = {{LOC_BITS{1'b0}}, write_pointer_reg};
    assign sector_ext = {{(EXT_BITS-SECTOR_BITS-1){1'b0}}, byte_sector};

    // collected bytes, padded where not yet filled
    assign pack_b0 = (pending_count_reg > 2'd0) ? pending_bytes_reg[0] : PAD_BYTE;
    assign pack_b1 = (pending_count_reg > 2'd1) ? pending_bytes_reg[1] : PAD_BYTE;
    assign pack_b2 = (pending_count_reg > 2'd2) ? pending_bytes_reg[2] : PAD_BYTE;

    // next state and result
    always_comb
    begin
        write_pointer_next = write_pointer_reg;
        pending_count_next = pending_count_reg;
        next_erase_next    = next_erase_reg;
        out_valid_next     = out_valid_reg & out_stall;
        out_item_next      = out_item_reg;
        store_byte         = 1'b0;
        if (in_accept)
        begin
            unique case (in_item.opcode)
                OP_START:
                begin
                    write_pointer_next = start_pointer;
                    pending_count_next = 2'd0;
                    next_erase_next    = {1'b0, start_pointer[ADDR_BITS-1:SHIFT]};
                end
                OP_DATA:
                begin
                    if (pending_count_reg == 2'd3)
                    begin
                        // word complete
                        write_pointer_next      = write_pointer_reg + ADDR_BITS'(WORD_BYTES);
                        pending_count_next      = 2'd0;
                        out_valid_next          = 1'b1;
                        out_item_next.command   = CMD_PROGRAM;
                        out_item_next.location  = wp_ext[LOC_BITS-1:0];
                        out_item_next.word_data = {in_item.data_byte, pack_b2,
                                                   pack_b1, pack_b0};
                    end
                    else
                    begin
                        store_byte         = 1'b1;
                        pending_count_next = pending_count_reg + 2'd1;
                        // first byte in a sector not yet erased
                        if (byte_sector >= next_erase_reg)
                        begin
                            next_erase_next         = byte_sector + (SECTOR_BITS+1)'(1);
                            out_valid_next          = 1'b1;
                            out_item_next.command   = CMD_ERASE;
                            out_item_next.location  = sector_ext[LOC_BITS-1:0];
                            out_item_next.word_data = '0;
                        end
                    end
                end
                OP_FINISH:
                begin
                    if (pending_count_reg != 2'd0)
                    begin
                        write_pointer_next      = write_pointer_reg + ADDR_BITS'(WORD_BYTES);
                        pending_count_next      = 2'd0;
                        out_valid_next          = 1'b1;
                        out_item_next.command   = CMD_PROGRAM;
                        out_item_next.location  = wp_ext[LOC_BITS-1:0];
                        out_item_next.word_data = {PAD_BYTE, pack_b2, pack_b1, pack_b0};
                    end
                end
                default:
                begin
                    // unused opcode: no effect
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_address_reg <= '0;
            write_pointer_reg <= '0;
            pending_count_reg <= '0;
            next_erase_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                start_address_reg <= cfg_data;
            end
            write_pointer_reg <= write_pointer_next;
            pending_count_reg <= pending_count_next;
            next_erase_reg    <= next_erase_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        if (store_byte)
        begin
            pending_bytes_reg[pending_count_reg] <= in_item.data_byte;
        end
    end

    // checks
    `FWWP_ASSERT_NEXT(a_start_clears, in_accept && in_item.opcode == OP_START, pending_count_reg == 2'd0 && !out_valid_reg, "start left bytes pending or a result")
    `FWWP_ASSERT_NEXT(a_word_emits, in_accept && in_item.opcode == OP_DATA && pending_count_reg == 2'd3, out_valid_reg && out_item_reg.command == CMD_PROGRAM, "full word not emitted")
    `FWWP_ASSERT(a_erase_mono, !(in_accept && in_item.opcode == OP_START) |=> next_erase_reg >= $past(next_erase_reg), "erase mark moved back")
    `FWWP_ASSERT(a_stall_full, in_stall |-> ##1 (out_valid_reg && $stable(out_item_reg)), "stalled result lost")

endmodule

FILE: tb/flash_word_write_packer_test.sv
`timescale 1ns / 1ps

module flash_word_write_packer_test;

    import fwwp_pkg::*;

    localparam int ERASE_UNIT_BYTES = 4096;
    localparam int PTR_BITS = 24;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS = 165;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [LOC_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_item;

    // pacing, percent of cycles
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // items waiting to be sent, and flash commands still due from the block
    in_item_t stream_q[$];
    out_item_t flash_cmd_q[$];
    out_item_t due_cmd;

    int items_queued = 0;
    int items_taken = 0;
    int erases_seen = 0;
    int programs_seen = 0;
    int errors = 0;

    // shadow of the block's registers
    logic [LOC_BITS-1:0] start_addr_shadow = '0;
    logic [PTR_BITS-1:0] write_ptr = '0;
    int pend_cnt = 0;
    logic [7:0] pend_bytes [3];
    int next_erase = 0;

    flash_word_write_packer #(
        .SECTOR_BYTES(ERASE_UNIT_BYTES),
        .ADDR_BITS(PTR_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("Timeout: %0d of %0d items taken, %0d commands due",
                 items_taken, items_queued, flash_cmd_q.size());
        $display("Some tests failed");
        $finish;
    end

    // pack collected bytes plus the closing byte, pad missing ones
    function automatic logic [WORD_BITS-1:0] pack_flash_word(logic [7:0] last_byte);
        logic [WORD_BITS-1:0] w;
        w = '0;
        for (int i = 0; i < 3; i++)
            w[8*i +: 8] = (i < pend_cnt) ? pend_bytes[i] : PAD_BYTE;
        w[31:24] = last_byte;
        return w;
    endfunction

    function automatic void emit_program(logic [7:0] last_byte);
        out_item_t c;
        c.command = CMD_PROGRAM;
        c.location = LOC_BITS'(write_ptr);
        c.word_data = pack_flash_word(last_byte);
        flash_cmd_q.push_back(c);
        write_ptr = write_ptr + PTR_BITS'(WORD_BYTES);
        pend_cnt = 0;
    endfunction

    // flash commands caused by one accepted item
    function automatic void predict_flash_cmd(in_item_t it);
        logic [PTR_BITS-1:0] addr;
        int sector;
        out_item_t c;
        case (it.opcode)
            OP_START:
            begin
                write_ptr = PTR_BITS'(start_addr_shadow) & ~PTR_BITS'(3);
                pend_cnt = 0;
                next_erase = int'(write_ptr) / ERASE_UNIT_BYTES;
            end
            OP_DATA:
            begin
                addr = write_ptr + PTR_BITS'(pend_cnt);
                sector = int'(addr) / ERASE_UNIT_BYTES;
                if (pend_cnt >= 3)
                    emit_program(it.data_byte);
                else
                begin
                    pend_bytes[pend_cnt] = it.data_byte;
                    pend_cnt++;
                    if (sector >= next_erase)
                    begin
                        next_erase = sector + 1;
                        c.command = CMD_ERASE;
                        c.location = LOC_BITS'(sector);
                        c.word_data = '0;
                        flash_cmd_q.push_back(c);
                    end
                end
            end
            OP_FINISH:
            begin
                if (pend_cnt != 0)
                    emit_program(PAD_BYTE);
            end
            default:
            begin
                // unused opcode is ignored
            end
        endcase
    endfunction

    // driver: present queued items, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_flash_cmd(in_item);
                items_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_item <= stream_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each taken command against the oldest due one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (flash_cmd_q.size() == 0)
                begin
                    $error("unexpected command %0d loc %h word %h",
                           out_item.command, out_item.location, out_item.word_data);
                    errors++;
                end
                else
                begin
                    due_cmd = flash_cmd_q.pop_front();
                    if (out_item.command !== due_cmd.command)
                    begin
                        $error("command: expected %0d, got %0d",
                               due_cmd.command, out_item.command);
                        errors++;
                    end
                    if (out_item.location !== due_cmd.location)
                    begin
                        $error("location: expected %h, got %h",
                               due_cmd.location, out_item.location);
                        errors++;
                    end
                    if (out_item.word_data !== due_cmd.word_data)
                    begin
                        $error("word_data: expected %h, got %h",
                               due_cmd.word_data, out_item.word_data);
                        errors++;
                    end
                    if (due_cmd.command == CMD_ERASE)
                        erases_seen++;
                    else
                        programs_seen++;
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic void queue_item(logic [1:0] op, logic [7:0] b);
        in_item_t it;
        it.opcode = op;
        it.data_byte = b;
        stream_q.push_back(it);
        items_queued++;
    endfunction

    task automatic set_pacing(int mode);
        case (mode)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 84; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 84; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
        endcase
    endtask

    // wait until every item is taken and every command checked
    task automatic drain_flash_cmds();
        while (items_taken != items_queued || flash_cmd_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_start_address(logic [LOC_BITS-1:0] addr);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= addr;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        start_addr_shadow = addr;
    endtask

    // mostly start / bytes / finish runs, some stray bytes and noise
    task automatic queue_random_image(int count);
        int added;
        int len;
        int r;
        added = 0;
        while (added < count)
        begin
            r = $urandom_range(99);
            if (r < 80)
            begin
                r = $urandom_range(99);
                if (r < 85)
                    len = $urandom_range(1, 20);
                else if (r < 97)
                    len = $urandom_range(21, 80);
                else
                    len = $urandom_range(200, 600);
                queue_item(OP_START, 8'($urandom));
                for (int i = 0; i < len; i++)
                    queue_item(OP_DATA, 8'($urandom));
                added += len + 1;
                if ($urandom_range(9) != 0)
                begin
                    queue_item(OP_FINISH, 8'($urandom));
                    added++;
                end
            end
            else if (r < 90)
            begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    queue_item(OP_DATA, 8'($urandom));
                added += len;
            end
            else if (r < 94)
                queue_item(OP_UNUSED, 8'($urandom));
            else if (r < 98)
            begin
                queue_item(OP_FINISH, 8'($urandom));
                added++;
            end
            else
            begin
                queue_item(OP_START, 8'($urandom));
                added++;
            end
        end
    endtask

    initial
    begin
        logic [LOC_BITS-1:0] base;
        for (int i = 0; i < 3; i++)
            pend_bytes[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset start address: bytes before any start
        set_pacing(0);
        queue_item(OP_DATA, 8'h00);
        queue_item(OP_UNUSED, 8'hFF);
        queue_item(OP_FINISH, 8'h00);
        queue_item(OP_FINISH, 8'hFF);
        queue_item(OP_DATA, 8'hFF);
        queue_item(OP_DATA, 8'hA5);
        queue_item(OP_DATA, 8'h5A);
        queue_item(OP_FINISH, 8'h00);
        queue_item(OP_DATA, 8'h01);
        queue_item(OP_DATA, 8'h02);
        queue_item(OP_DATA, 8'h03);
        queue_item(OP_DATA, 8'h80);
        queue_item(OP_START, 8'hFF);
        queue_item(OP_DATA, 8'h7E);
        queue_item(OP_FINISH, 8'h00);
        drain_flash_cmds();

        // unaligned top address: last sector, then pointer wrap
        write_start_address(24'hFFFFFF);
        queue_item(OP_START, 8'h00);
        for (int i = 0; i < 8; i++)
            queue_item(OP_DATA, 8'(8'h11 * i));
        queue_item(OP_FINISH, 8'h00);
        drain_flash_cmds();

        // random phases, each with its own start address and pacing
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: base = 24'h000000;
                1: base = 24'hFFFFFC;
                2: base = {12'($urandom), 8'hFF, 4'($urandom)};
                3: base = 24'($urandom);
                4: base = {12'hFFF, 12'hF00 | 12'($urandom_range(255))};
                5: base = {12'($urandom), 12'($urandom)} & ~24'h3;
                6: base = {12'($urandom), 12'hFFC};
                default: base = 24'($urandom) | 24'h3;
            endcase
            set_pacing(ph % 4);
            write_start_address(base);
            queue_random_image(PHASE_ITEMS);
            drain_flash_cmds();
        end

        if (flash_cmd_q.size() != 0)
        begin
            $error("%0d commands never arrived", flash_cmd_q.size());
            errors++;
        end
        $display("Sent %0d items over 10 start-address settings and 4 pacing modes;",
                 items_queued);
        $display("checked %0d sector erases and %0d word programs.",
                 erases_seen, programs_seen);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/fwwp_pkg.sv
rtl/flash_word_write_packer.sv
tb/flash_word_write_packer_test.sv
